[rtl/rar_pkg.sv]
// Shared types, codes and constants of the ray absorption replay unit.
package rar_pkg;

   localparam int unsigned DefMaxCells        = 256;
   localparam int unsigned DefMaxChloroplasts = 64;
   localparam int unsigned DefMaxTriangles    = 4096;
   localparam int unsigned DefMaxOtherCells   = 256;

   localparam int unsigned ConcDepth   = 256;
   localparam int unsigned TaylorOrder = 6;
   localparam int unsigned SquareCount = 8;
   localparam logic [31:0] ExpLimit    = 32'd17;

   localparam logic KIND_EVENT = 1'b0;
   localparam logic KIND_LOAD  = 1'b1;

   localparam logic [2:0] CLASS_LEAF        = 3'd0;
   localparam logic [2:0] CLASS_WALL        = 3'd1;
   localparam logic [2:0] CLASS_CHLOROPLAST = 3'd2;
   localparam logic [2:0] CLASS_OTHER_CELL  = 3'd3;
   localparam logic [2:0] CLASS_VACUOLE     = 3'd4;

   localparam logic [1:0] STATUS_ABSORB   = 2'd0;
   localparam logic [1:0] STATUS_REFLECT  = 2'd1;
   localparam logic [1:0] STATUS_TRANSMIT = 2'd2;
   localparam logic [1:0] STATUS_UNKNOWN  = 2'd3;

   localparam logic [1:0] CSR_WATER       = 2'd0;
   localparam logic [1:0] CSR_CHLOROPHYLL = 2'd1;
   localparam logic [1:0] CSR_THRESHOLD   = 2'd2;

   typedef struct packed {
      logic       capture;
      logic       coef;
      logic       xmul;
      logic       tmul;
      logic       tdiv;
      logic       tacc;
      logic       square;
      logic       keep;
      logic       finish;
      logic [2:0] order;
   } rar_cmd_type;

   typedef struct packed {
      logic absorbing;
      logic x_big;
   } rar_status_type;

   // ceil(2^32 / k): exact quotient for numerators below 2^29
   function automatic logic [32:0] div_magic(input logic [2:0] k);
      logic [32:0] m;
      begin
         case (k)
            3'd1:    m = 33'h1_0000_0000;
            3'd2:    m = 33'h0_8000_0000;
            3'd3:    m = 33'h0_5555_5556;
            3'd4:    m = 33'h0_4000_0000;
            3'd5:    m = 33'h0_3333_3334;
            3'd6:    m = 33'h0_2AAA_AAAB;
            default: m = 33'h0;
         endcase
         return m;
      end
   endfunction

   function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [23:0] b);
      logic [48:0] s;
      begin
         s = 49'(a) + 49'(b);
         return s[48] ? {48{1'b1}} : s[47:0];
      end
   endfunction

endpackage

[rtl/rar_ctrl.sv]
// Sequencer of the ray absorption replay unit.
module rar_ctrl
   import rar_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  rar_status_type status,
   output rar_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_COEF, ST_XMUL, ST_DECIDE, ST_TMUL,
      ST_TDIV, ST_TACC, ST_SQUARE, ST_KEEP, ST_FINISH
   } state_type;

   state_type  state_ff;
   logic [2:0] order_ff;
   logic [2:0] square_ff;
   logic       rsp_valid_ff;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd         = '0;
      cmd.order   = order_ff;
      cmd.capture = (state_ff == ST_IDLE) && req_valid;
      cmd.coef    = (state_ff == ST_COEF);
      cmd.xmul    = (state_ff == ST_XMUL);
      cmd.tmul    = (state_ff == ST_TMUL);
      cmd.tdiv    = (state_ff == ST_TDIV);
      cmd.tacc    = (state_ff == ST_TACC);
      cmd.square  = (state_ff == ST_SQUARE);
      cmd.keep    = (state_ff == ST_KEEP);
      cmd.finish  = (state_ff == ST_FINISH) && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         order_ff     <= '0;
         square_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) state_ff <= ST_COEF;
            end
            ST_COEF:   state_ff <= ST_XMUL;
            ST_XMUL:   state_ff <= ST_DECIDE;
            ST_DECIDE: begin
               if (!status.absorbing) begin
                  state_ff <= ST_FINISH;
               end else if (status.x_big) begin
                  state_ff <= ST_KEEP;
               end else begin
                  order_ff <= 3'd1;
                  state_ff <= ST_TMUL;
               end
            end
            ST_TMUL:   state_ff <= ST_TDIV;
            ST_TDIV:   state_ff <= ST_TACC;
            ST_TACC: begin
               if (order_ff == 3'(TaylorOrder)) begin
                  square_ff <= '0;
                  state_ff  <= ST_SQUARE;
               end else begin
                  order_ff <= order_ff + 3'd1;
                  state_ff <= ST_TMUL;
               end
            end
            ST_SQUARE: begin
               square_ff <= square_ff + 3'd1;
               if (square_ff == 3'(SquareCount - 1)) state_ff <= ST_KEEP;
            end
            ST_KEEP:   state_ff <= ST_FINISH;
            ST_FINISH: begin
               if (slot_free) state_ff <= ST_IDLE;
            end
            default:   state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

[rtl/rar_datapath.sv]
// Datapath of the ray absorption replay unit: ray state, coefficient and exponential.
module rar_datapath
   import rar_pkg::*;
#(
   parameter int unsigned MAX_CELLS        = DefMaxCells,
   parameter int unsigned MAX_CHLOROPLASTS = DefMaxChloroplasts,
   parameter int unsigned MAX_TRIANGLES    = DefMaxTriangles,
   parameter int unsigned MAX_OTHER_CELLS  = DefMaxOtherCells
) (
   input  logic           clock,
   input  logic           reset,
   input  rar_cmd_type    cmd,
   output rar_status_type status,
   input  logic           csr_valid,
   input  logic [1:0]     csr_index,
   input  logic [31:0]    csr_data,
   input  logic           req_kind,
   input  logic [11:0]    req_ray_x,
   input  logic [11:0]    req_ray_y,
   input  logic [31:0]    req_distance,
   input  logic [2:0]     req_object_class,
   input  logic [7:0]     req_cell_number,
   input  logic [5:0]     req_chloroplast_number,
   input  logic [11:0]    req_triangle,
   input  logic           req_inner_side,
   input  logic [23:0]    req_start_intensity,
   input  logic [1:0]     req_event_status,
   input  logic [23:0]    req_load_value,
   output logic           rsp_absorb_valid,
   output logic [23:0]    rsp_absorbed_amount,
   output logic [2:0]     rsp_hit_class,
   output logic [7:0]     rsp_hit_cell,
   output logic [5:0]     rsp_hit_chloroplast,
   output logic [11:0]    rsp_hit_triangle,
   output logic           rsp_hit_inner,
   output logic [47:0]    rsp_reflected_total,
   output logic [47:0]    rsp_transmitted_total,
   output logic [47:0]    rsp_discarded_total,
   output logic           rsp_leftover_error
);

   logic [31:0] water_ff, chl_coef_ff;
   logic [23:0] thr_ff;

   logic        kind_ff;
   logic [11:0] rx_ff, ry_ff;
   logic [31:0] dist_ff;
   logic [2:0]  cls_ff;
   logic [7:0]  cell_ff;
   logic [5:0]  chl_num_ff;
   logic [11:0] tri_ff;
   logic        inner_ff;
   logic [23:0] start_ff;
   logic [1:0]  evt_status_ff;
   logic [23:0] load_ff;

   logic [23:0] conc_mem [ConcDepth];
   logic [23:0] conc_rd_ff;

   logic [11:0] prev_x_ff, prev_y_ff;
   logic        no_ray_ff, following_ff, error_ff;
   logic [23:0] cur_ff;
   logic [47:0] refl_ff, trans_ff, disc_ff;

   logic [55:0] prod_ff;
   logic [63:0] x_ff;
   logic [32:0] term_ff, sum_ff;
   logic [61:0] p_ff, q_ff;
   logic [23:0] kept_ff;

   logic        rsp_absorb_valid_ff, rsp_hit_inner_ff, rsp_error_ff;
   logic [23:0] rsp_amount_ff;
   logic [2:0]  rsp_class_ff;
   logic [7:0]  rsp_cell_ff;
   logic [5:0]  rsp_chl_ff;
   logic [11:0] rsp_tri_ff;
   logic [47:0] rsp_refl_ff, rsp_trans_ff, rsp_disc_ff;

   logic        new_ray, event_item, process, obj_ok, absorbing;
   logic [23:0] work_int;
   logic [31:0] chl_sat, coef;
   logic [28:0] y_val, t_val, quot;
   logic [63:0] sq_prod;
   logic [32:0] factor;
   logic [56:0] keep_prod;

   logic [23:0] ci, absorbed_in;
   logic        valid_in, following_in, error_in;
   logic [47:0] refl_in, trans_in, disc_in;

   assign new_ray    = no_ray_ff || (rx_ff != prev_x_ff) || (ry_ff != prev_y_ff);
   assign event_item = (kind_ff == KIND_EVENT);
   assign process    = event_item && (new_ray || following_ff);
   assign work_int   = new_ray ? start_ff : cur_ff;

   always_comb begin
      obj_ok = (cls_ff <= CLASS_VACUOLE) && (32'(tri_ff) < MAX_TRIANGLES);
      if ((cls_ff == CLASS_WALL || cls_ff == CLASS_CHLOROPLAST || cls_ff == CLASS_VACUOLE)
          && (32'(cell_ff) >= MAX_CELLS)) obj_ok = 1'b0;
      if (cls_ff == CLASS_OTHER_CELL && 32'(cell_ff) >= MAX_OTHER_CELLS) obj_ok = 1'b0;
      if (cls_ff == CLASS_CHLOROPLAST && 32'(chl_num_ff) >= MAX_CHLOROPLASTS) obj_ok = 1'b0;
   end

   assign absorbing        = process && (evt_status_ff == STATUS_ABSORB) && obj_ok;
   assign status.absorbing = absorbing;
   assign status.x_big     = (x_ff[63:32] >= ExpLimit);

   assign chl_sat = (|prod_ff[55:48]) ? 32'hFFFF_FFFF : prod_ff[47:16];

   always_comb begin
      case (cls_ff)
         CLASS_LEAF:        coef = '0;
         CLASS_WALL:        coef = inner_ff ? water_ff : '0;
         CLASS_CHLOROPLAST: coef = inner_ff ? chl_sat : water_ff;
         default:           coef = water_ff;
      endcase
   end

   assign y_val     = x_ff[36:8];
   assign t_val     = p_ff[60:32];
   assign quot      = q_ff[60:32];
   assign sq_prod   = 64'(sum_ff[31:0]) * 64'(sum_ff[31:0]);
   assign factor    = status.x_big ? '0 : sum_ff;
   assign keep_prod = 57'(work_int) * 57'(factor);

   always_comb begin
      ci           = work_int;
      absorbed_in  = '0;
      valid_in     = 1'b0;
      error_in     = error_ff;
      refl_in      = refl_ff;
      trans_in     = trans_ff;
      disc_in      = disc_ff;
      following_in = new_ray ? 1'b1 : following_ff;
      if (event_item && new_ray && (cur_ff > thr_ff)) error_in = 1'b1;
      if (process) begin
         case (evt_status_ff)
            STATUS_REFLECT: begin
               refl_in = sat_add48(refl_ff, ci);
               ci      = '0;
            end
            STATUS_TRANSMIT: begin
               trans_in = sat_add48(trans_ff, ci);
               ci       = '0;
            end
            STATUS_ABSORB: begin
               if (obj_ok) begin
                  absorbed_in = ci - kept_ff;
                  ci          = kept_ff;
                  valid_in    = 1'b1;
               end
            end
            default: ci = work_int;
         endcase
         if (ci < thr_ff) begin
            following_in = 1'b0;
            disc_in      = sat_add48(disc_ff, ci);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         water_ff    <= '0;
         chl_coef_ff <= '0;
         thr_ff      <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WATER:       water_ff    <= csr_data;
            CSR_CHLOROPHYLL: chl_coef_ff <= csr_data;
            CSR_THRESHOLD:   thr_ff      <= csr_data[23:0];
            default:         thr_ff      <= thr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff       <= req_kind;
         rx_ff         <= req_ray_x;
         ry_ff         <= req_ray_y;
         dist_ff       <= req_distance;
         cls_ff        <= req_object_class;
         cell_ff       <= req_cell_number;
         chl_num_ff    <= req_chloroplast_number;
         tri_ff        <= req_triangle;
         inner_ff      <= req_inner_side;
         start_ff      <= req_start_intensity;
         evt_status_ff <= req_event_status;
         load_ff       <= req_load_value;
         conc_rd_ff    <= conc_mem[req_cell_number];
      end
      if (cmd.finish && kind_ff == KIND_LOAD && 32'(cell_ff) < MAX_CELLS) begin
         conc_mem[cell_ff] <= load_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.coef) prod_ff <= 56'(chl_coef_ff) * 56'(conc_rd_ff);
      if (cmd.xmul) begin
         x_ff    <= 64'(coef) * 64'(dist_ff);
         term_ff <= 33'h1_0000_0000;
         sum_ff  <= 33'h1_0000_0000;
      end
      if (cmd.tmul) p_ff <= 62'(term_ff) * 62'(y_val);
      if (cmd.tdiv) q_ff <= 62'(t_val) * 62'(div_magic(cmd.order));
      if (cmd.tacc) begin
         term_ff <= 33'(quot);
         if (cmd.order[0]) begin
            sum_ff <= sum_ff - 33'(quot);
         end else begin
            sum_ff <= sum_ff + 33'(quot);
         end
      end
      if (cmd.square && !sum_ff[32]) sum_ff <= {1'b0, sq_prod[63:32]};
      if (cmd.keep) kept_ff <= keep_prod[55:32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         no_ray_ff    <= 1'b1;
         cur_ff       <= '0;
         following_ff <= 1'b0;
         refl_ff      <= '0;
         trans_ff     <= '0;
         disc_ff      <= '0;
         error_ff     <= 1'b0;
      end else if (cmd.finish && event_item) begin
         if (new_ray) begin
            prev_x_ff <= rx_ff;
            prev_y_ff <= ry_ff;
            no_ray_ff <= 1'b0;
         end
         if (process) cur_ff <= ci;
         following_ff <= following_in;
         refl_ff      <= refl_in;
         trans_ff     <= trans_in;
         disc_ff      <= disc_in;
         error_ff     <= error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_absorb_valid_ff <= valid_in;
         rsp_amount_ff       <= absorbed_in;
         rsp_class_ff        <= valid_in ? cls_ff : '0;
         rsp_cell_ff         <= valid_in ? cell_ff : '0;
         rsp_chl_ff          <= valid_in ? chl_num_ff : '0;
         rsp_tri_ff          <= valid_in ? tri_ff : '0;
         rsp_hit_inner_ff    <= valid_in && inner_ff;
         rsp_refl_ff         <= event_item ? refl_in : refl_ff;
         rsp_trans_ff        <= event_item ? trans_in : trans_ff;
         rsp_disc_ff         <= event_item ? disc_in : disc_ff;
         rsp_error_ff        <= event_item ? error_in : error_ff;
      end
   end

   assign rsp_absorb_valid      = rsp_absorb_valid_ff;
   assign rsp_absorbed_amount   = rsp_amount_ff;
   assign rsp_hit_class         = rsp_class_ff;
   assign rsp_hit_cell          = rsp_cell_ff;
   assign rsp_hit_chloroplast   = rsp_chl_ff;
   assign rsp_hit_triangle      = rsp_tri_ff;
   assign rsp_hit_inner         = rsp_hit_inner_ff;
   assign rsp_reflected_total   = rsp_refl_ff;
   assign rsp_transmitted_total = rsp_trans_ff;
   assign rsp_discarded_total   = rsp_disc_ff;
   assign rsp_leftover_error    = rsp_error_ff;

endmodule

[rtl/ray_absorption_replay_unit.sv]
// Top level of the ray absorption replay unit.
// Loads, reflect, transmit and skipped events finish after the decision; an absorb event past
// the exponent cutoff adds a keep step, others six Taylor terms and 8 squarings before it.
// A new request is taken only while idle; a result waits in the output register.
// Reset: synchronous, active high; clears ray state, totals, error flag and configuration registers.
// The concentration table is not cleared; entries are defined once loaded.
module ray_absorption_replay_unit
   import rar_pkg::*;
#(
   parameter int unsigned MAX_CELLS        = DefMaxCells,
   parameter int unsigned MAX_CHLOROPLASTS = DefMaxChloroplasts,
   parameter int unsigned MAX_TRIANGLES    = DefMaxTriangles,
   parameter int unsigned MAX_OTHER_CELLS  = DefMaxOtherCells
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [11:0] req_ray_x,
   input  logic [11:0] req_ray_y,
   input  logic [31:0] req_distance,
   input  logic [2:0]  req_object_class,
   input  logic [7:0]  req_cell_number,
   input  logic [5:0]  req_chloroplast_number,
   input  logic [11:0] req_triangle,
   input  logic        req_inner_side,
   input  logic [23:0] req_start_intensity,
   input  logic [1:0]  req_event_status,
   input  logic [23:0] req_load_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_absorb_valid,
   output logic [23:0] rsp_absorbed_amount,
   output logic [2:0]  rsp_hit_class,
   output logic [7:0]  rsp_hit_cell,
   output logic [5:0]  rsp_hit_chloroplast,
   output logic [11:0] rsp_hit_triangle,
   output logic        rsp_hit_inner,
   output logic [47:0] rsp_reflected_total,
   output logic [47:0] rsp_transmitted_total,
   output logic [47:0] rsp_discarded_total,
   output logic        rsp_leftover_error,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   rar_cmd_type    cmd;
   rar_status_type status;

   assign csr_ready = 1'b1;

   rar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rar_datapath #(
      .MAX_CELLS        (MAX_CELLS),
      .MAX_CHLOROPLASTS (MAX_CHLOROPLASTS),
      .MAX_TRIANGLES    (MAX_TRIANGLES),
      .MAX_OTHER_CELLS  (MAX_OTHER_CELLS)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .csr_valid              (csr_valid),
      .csr_index              (csr_index),
      .csr_data               (csr_data),
      .req_kind               (req_kind),
      .req_ray_x              (req_ray_x),
      .req_ray_y              (req_ray_y),
      .req_distance           (req_distance),
      .req_object_class       (req_object_class),
      .req_cell_number        (req_cell_number),
      .req_chloroplast_number (req_chloroplast_number),
      .req_triangle           (req_triangle),
      .req_inner_side         (req_inner_side),
      .req_start_intensity    (req_start_intensity),
      .req_event_status       (req_event_status),
      .req_load_value         (req_load_value),
      .rsp_absorb_valid       (rsp_absorb_valid),
      .rsp_absorbed_amount    (rsp_absorbed_amount),
      .rsp_hit_class          (rsp_hit_class),
      .rsp_hit_cell           (rsp_hit_cell),
      .rsp_hit_chloroplast    (rsp_hit_chloroplast),
      .rsp_hit_triangle       (rsp_hit_triangle),
      .rsp_hit_inner          (rsp_hit_inner),
      .rsp_reflected_total    (rsp_reflected_total),
      .rsp_transmitted_total  (rsp_transmitted_total),
      .rsp_discarded_total    (rsp_discarded_total),
      .rsp_leftover_error     (rsp_leftover_error)
   );

endmodule

[test/ray_absorption_replay_checker.sv]
// Checker for the ray absorption replay unit: tracks requests, predicts responses, compares them.
module ray_absorption_replay_checker
   import rar_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_kind,
   input  logic [11:0] req_ray_x,
   input  logic [11:0] req_ray_y,
   input  logic [31:0] req_distance,
   input  logic [2:0]  req_object_class,
   input  logic [7:0]  req_cell_number,
   input  logic [5:0]  req_chloroplast_number,
   input  logic [11:0] req_triangle,
   input  logic        req_inner_side,
   input  logic [23:0] req_start_intensity,
   input  logic [1:0]  req_event_status,
   input  logic [23:0] req_load_value,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_absorb_valid,
   input  logic [23:0] rsp_absorbed_amount,
   input  logic [2:0]  rsp_hit_class,
   input  logic [7:0]  rsp_hit_cell,
   input  logic [5:0]  rsp_hit_chloroplast,
   input  logic [11:0] rsp_hit_triangle,
   input  logic        rsp_hit_inner,
   input  logic [47:0] rsp_reflected_total,
   input  logic [47:0] rsp_transmitted_total,
   input  logic [47:0] rsp_discarded_total,
   input  logic        rsp_leftover_error,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          mismatch_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] OneQ32 = 64'd1 << 32;
   localparam logic [63:0] ExpCutoff = 64'd17 << 32;

   typedef struct {
      logic        absorb_valid;
      logic [23:0] absorbed;
      logic [2:0]  cls;
      logic [7:0]  cell_idx;
      logic [5:0]  chl;
      logic [11:0] tri_idx;
      logic        inner;
      logic [47:0] reflected;
      logic [47:0] transmitted;
      logic [47:0] discarded;
      logic        error;
   } ray_response_type;

   ray_response_type expected_responses[$];

   logic [31:0] water_coef, chl_coef;
   logic [23:0] threshold;
   logic [11:0] last_x, last_y;
   logic        first_ray, tracking, leftover_flag;
   logic [23:0] intensity;
   logic [47:0] reflected_acc, transmitted_acc, discarded_acc;
   logic [23:0] concentration[256];

   function automatic logic [47:0] saturating_add(logic [47:0] a, logic [23:0] b);
      logic [48:0] s;
      s = {1'b0, a} + 49'(b);
      return s[48] ? {48{1'b1}} : s[47:0];
   endfunction

   function automatic logic [63:0] attenuation(logic [63:0] x);
      logic [63:0] y, term, acc;
      if (x >= ExpCutoff) return 64'd0;
      y = x >> 8;
      term = OneQ32;
      acc = OneQ32;
      for (int k = 1; k <= 6; k++) begin
         term = ((term * y) >> 32) / k;
         if (k % 2 == 1) acc = acc - term;
         else acc = acc + term;
      end
      for (int k = 0; k < 8; k++) begin
         if (acc < OneQ32) acc = (acc * acc) >> 32;
      end
      return acc;
   endfunction

   function automatic logic [31:0] path_coefficient(logic [2:0] cls, logic [7:0] cell_idx,
                                                    logic inner);
      logic [63:0] p;
      case (cls)
         CLASS_LEAF: return 32'd0;
         CLASS_WALL: return inner ? water_coef : 32'd0;
         CLASS_CHLOROPLAST: begin
            if (!inner) return water_coef;
            p = (64'(chl_coef) * 64'(concentration[cell_idx])) >> 16;
            return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
         end
         default: return water_coef;
      endcase
   endfunction

   function automatic ray_response_type replay_event();
      ray_response_type r;
      logic             active;
      logic [63:0]      f;
      logic [23:0]      kept;
      r = '{default: '0};
      active = 1'b0;
      if (req_kind == KIND_LOAD) begin
         concentration[req_cell_number] = req_load_value;
      end else begin
         if (first_ray || req_ray_x != last_x || req_ray_y != last_y) begin
            if (intensity > threshold) leftover_flag = 1'b1;
            last_x = req_ray_x;
            last_y = req_ray_y;
            first_ray = 1'b0;
            intensity = req_start_intensity;
            tracking = 1'b1;
            active = 1'b1;
         end else if (tracking) begin
            active = 1'b1;
         end
         if (active) begin
            if (req_event_status == STATUS_REFLECT) begin
               reflected_acc = saturating_add(reflected_acc, intensity);
               intensity = '0;
            end else if (req_event_status == STATUS_TRANSMIT) begin
               transmitted_acc = saturating_add(transmitted_acc, intensity);
               intensity = '0;
            end else if (req_event_status == STATUS_ABSORB &&
                         req_object_class <= CLASS_VACUOLE) begin
               f = attenuation(64'(path_coefficient(req_object_class, req_cell_number,
                                                    req_inner_side)) * 64'(req_distance));
               kept = 24'((64'(intensity) * f) >> 32);
               r.absorb_valid = 1'b1;
               r.absorbed = intensity - kept;
               r.cls = req_object_class;
               r.cell_idx = req_cell_number;
               r.chl = req_chloroplast_number;
               r.tri_idx = req_triangle;
               r.inner = req_inner_side;
               intensity = kept;
            end
            if (intensity < threshold) begin
               tracking = 1'b0;
               discarded_acc = saturating_add(discarded_acc, intensity);
            end
         end
      end
      r.reflected = reflected_acc;
      r.transmitted = transmitted_acc;
      r.discarded = discarded_acc;
      r.error = leftover_flag;
      return r;
   endfunction

   function automatic void compare_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      ray_response_type e;
      if (reset) begin
         mismatch_count = 0;
         water_coef = '0;
         chl_coef = '0;
         threshold = '0;
         last_x = '0;
         last_y = '0;
         first_ray = 1'b1;
         tracking = 1'b0;
         leftover_flag = 1'b0;
         intensity = '0;
         reflected_acc = '0;
         transmitted_acc = '0;
         discarded_acc = '0;
         expected_responses.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WATER:       water_coef = csr_data;
               CSR_CHLOROPHYLL: chl_coef = csr_data;
               CSR_THRESHOLD:   threshold = csr_data[23:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               $display("%0t: response with none expected, expected nothing, actual absorbed %0h",
                        $time, rsp_absorbed_amount);
               mismatch_count++;
            end else begin
               e = expected_responses.pop_front();
               compare_field("absorb_valid", 48'(e.absorb_valid), 48'(rsp_absorb_valid));
               compare_field("absorbed_amount", 48'(e.absorbed), 48'(rsp_absorbed_amount));
               compare_field("hit_class", 48'(e.cls), 48'(rsp_hit_class));
               compare_field("hit_cell", 48'(e.cell_idx), 48'(rsp_hit_cell));
               compare_field("hit_chloroplast", 48'(e.chl), 48'(rsp_hit_chloroplast));
               compare_field("hit_triangle", 48'(e.tri_idx), 48'(rsp_hit_triangle));
               compare_field("hit_inner", 48'(e.inner), 48'(rsp_hit_inner));
               compare_field("reflected_total", e.reflected, rsp_reflected_total);
               compare_field("transmitted_total", e.transmitted, rsp_transmitted_total);
               compare_field("discarded_total", e.discarded, rsp_discarded_total);
               compare_field("leftover_error", 48'(e.error), 48'(rsp_leftover_error));
            end
         end
         if (req_valid && !req_stall) expected_responses.push_back(replay_event());
      end
      pending_count <= expected_responses.size();
   end
endmodule

[test/ray_absorption_replay_unit_test.sv]
// Testbench top for the ray absorption replay unit: stimulus, idling and verdict.
module ray_absorption_replay_unit_test;
   import rar_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IdleLimit = 3000;

   typedef struct {
      logic        kind;
      logic [11:0] x, y;
      logic [31:0] path_len;
      logic [2:0]  cls;
      logic [7:0]  cell_idx;
      logic [5:0]  chl;
      logic [11:0] tri_idx;
      logic        inner;
      logic [23:0] start;
      logic [1:0]  status;
      logic [23:0] load;
   } ray_request_type;

   logic        clock = 1'b0, reset = 1'b1;
   logic        req_valid = 1'b0, req_stall;
   logic        req_kind = 1'b0;
   logic [11:0] req_ray_x = '0, req_ray_y = '0;
   logic [31:0] req_distance = '0;
   logic [2:0]  req_object_class = '0;
   logic [7:0]  req_cell_number = '0;
   logic [5:0]  req_chloroplast_number = '0;
   logic [11:0] req_triangle = '0;
   logic        req_inner_side = 1'b0;
   logic [23:0] req_start_intensity = '0;
   logic [1:0]  req_event_status = '0;
   logic [23:0] req_load_value = '0;
   logic        rsp_valid, rsp_stall = 1'b0;
   logic        rsp_absorb_valid, rsp_hit_inner, rsp_leftover_error;
   logic [23:0] rsp_absorbed_amount;
   logic [2:0]  rsp_hit_class;
   logic [7:0]  rsp_hit_cell;
   logic [5:0]  rsp_hit_chloroplast;
   logic [11:0] rsp_hit_triangle;
   logic [47:0] rsp_reflected_total, rsp_transmitted_total, rsp_discarded_total;
   logic        csr_valid = 1'b0, csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   int   mismatch_count, pending_count;
   bit   idling = 1'b1;
   bit   loaded[256];
   int   loaded_cells[$];
   int   stall_left = 0;
   int   quiet_cycles = 0;

   ray_absorption_replay_unit dut (.*);

   ray_absorption_replay_checker checker_i (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   always @(negedge clock) begin
      if (stall_left != 0) stall_left--;
      else if (idling && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 8);
      rsp_stall <= (stall_left != 0);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic ray_request_type ray_event(int x, int y, int start, logic [1:0] status,
                                                 logic [2:0] cls, int cell_idx, logic inner,
                                                 logic [31:0] path_len);
      ray_request_type r;
      r.kind = KIND_EVENT;
      r.x = 12'(x);
      r.y = 12'(y);
      r.start = 24'(start);
      r.status = status;
      r.cls = cls;
      r.cell_idx = 8'(cell_idx);
      r.inner = inner;
      r.path_len = path_len;
      r.chl = 6'($urandom());
      r.tri_idx = 12'($urandom());
      r.load = 24'($urandom());
      return r;
   endfunction

   function automatic ray_request_type table_load(int cell_idx, logic [23:0] value);
      ray_request_type r;
      r = ray_event($urandom(), $urandom(), $urandom(), 2'($urandom()), 3'($urandom()),
                    cell_idx, 1'($urandom()), 32'($urandom()));
      r.kind = KIND_LOAD;
      r.load = value;
      return r;
   endfunction

   task automatic send_request(ray_request_type r);
      if (r.kind == KIND_EVENT && r.status == STATUS_ABSORB && r.cls == CLASS_CHLOROPLAST &&
          r.inner && !loaded[r.cell_idx]) r.inner = 1'b0;
      if (r.kind == KIND_LOAD && !loaded[r.cell_idx]) begin
         loaded[r.cell_idx] = 1'b1;
         loaded_cells.push_back(int'(r.cell_idx));
      end
      if (idling && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_kind = r.kind;
      req_ray_x = r.x;
      req_ray_y = r.y;
      req_distance = r.path_len;
      req_object_class = r.cls;
      req_cell_number = r.cell_idx;
      req_chloroplast_number = r.chl;
      req_triangle = r.tri_idx;
      req_inner_side = r.inner;
      req_start_intensity = r.start;
      req_event_status = r.status;
      req_load_value = r.load;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic write_register(logic [1:0] index, logic [31:0] value);
      csr_index = index;
      csr_data = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic drain();
      req_valid = 1'b0;
      wait (pending_count == 0);
      repeat (40) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic configure(logic [31:0] water, logic [31:0] chl, logic [23:0] thr);
      drain();
      write_register(CSR_WATER, water);
      write_register(CSR_CHLOROPHYLL, chl);
      write_register(CSR_THRESHOLD, 32'(thr));
   endtask

   task automatic run_random(int count);
      ray_request_type r;
      int              sent, n_events, x, y, start;
      logic [2:0]      cls;
      logic [1:0]      status;
      int              cell_idx;
      sent = 0;
      x = 0;
      y = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) == 0) begin
            r = table_load($urandom(), ($urandom_range(0, 3) == 0) ? 24'($urandom())
                                                               : 24'($urandom_range(0, 20'hFFFFF)));
            send_request(r);
            sent++;
         end else if ($urandom_range(0, 9) == 0) begin
            r = ray_event($urandom(), $urandom(), $urandom(), 2'($urandom()), 3'($urandom()),
                          $urandom(), 1'($urandom()), 32'($urandom()));
            send_request(r);
            sent++;
         end else begin
            if ($urandom_range(0, 7) != 0) begin
               x = ($urandom_range(0, 15) == 0) ? 4095 : $urandom_range(0, 4095);
               y = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(0, 4095);
            end
            case ($urandom_range(0, 7))
               0: start = 0;
               1: start = 'h800000;
               default: start = $urandom_range(0, 'h800000);
            endcase
            n_events = $urandom_range(1, 6);
            for (int i = 0; i < n_events; i++) begin
               case ($urandom_range(0, 19))
                  0, 1: status = STATUS_REFLECT;
                  2, 3: status = STATUS_TRANSMIT;
                  4:    status = STATUS_UNKNOWN;
                  default: status = STATUS_ABSORB;
               endcase
               cls = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                                   : 3'($urandom_range(0, 4));
               cell_idx = (loaded_cells.size() != 0 && $urandom_range(0, 3) != 0)
                          ? loaded_cells[$urandom_range(0, loaded_cells.size() - 1)]
                          : $urandom_range(0, 255);
               r = ray_event(x, y, start, status, cls, cell_idx, 1'($urandom()),
                             ($urandom_range(0, 3) == 0) ? 32'($urandom())
                                                         : 32'($urandom_range(0, 32'h60000)));
               send_request(r);
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      configure(32'h0001_0000, 32'h0000_8000, 24'h001000);
      send_request(table_load(0, 24'h010000));
      send_request(table_load(255, 24'hFFFFFF));
      send_request(ray_event(1, 1, 'h001000, STATUS_UNKNOWN, CLASS_LEAF, 0, 1'b0, 0));
      send_request(ray_event(2, 1, 'h800000, STATUS_ABSORB, CLASS_CHLOROPLAST, 0, 1'b1,
                             32'h0001_0000));
      send_request(ray_event(2, 1, 0, STATUS_ABSORB, CLASS_LEAF, 7, 1'b1, 32'h0002_0000));
      send_request(ray_event(2, 1, 0, STATUS_ABSORB, CLASS_WALL, 9, 1'b0, 32'h0000_8000));
      send_request(ray_event(2, 1, 0, STATUS_ABSORB, CLASS_WALL, 9, 1'b1, 32'h0000_8000));
      send_request(ray_event(2, 1, 0, STATUS_ABSORB, CLASS_OTHER_CELL, 255, 1'b1, 32'h4000));
      send_request(ray_event(2, 1, 0, STATUS_ABSORB, CLASS_VACUOLE, 3, 1'b0, 32'h2000));
      send_request(ray_event(2, 1, 0, STATUS_ABSORB, 3'd5, 3, 1'b1, 32'h2000));
      send_request(ray_event(2, 1, 0, STATUS_ABSORB, 3'd7, 3, 1'b0, 32'h2000));
      send_request(ray_event(2, 1, 0, STATUS_ABSORB, CLASS_CHLOROPLAST, 255, 1'b0, 32'h1000));
      send_request(ray_event(2, 1, 0, STATUS_ABSORB, CLASS_VACUOLE, 1, 1'b1, 32'hFFFF_FFFF));
      send_request(ray_event(2, 1, 0, STATUS_REFLECT, CLASS_LEAF, 0, 1'b0, 0));
      send_request(ray_event(4095, 4095, 'h800000, STATUS_REFLECT, CLASS_LEAF, 0, 1'b0, 0));
      send_request(ray_event(0, 0, 'h7FFFFF, STATUS_TRANSMIT, CLASS_LEAF, 0, 1'b0, 0));
      send_request(ray_event(3, 3, 'h800000, STATUS_UNKNOWN, CLASS_LEAF, 0, 1'b0, 0));
      send_request(ray_event(4, 4, 0, STATUS_ABSORB, CLASS_WALL, 0, 1'b1, 32'h1_0000));
      send_request(ray_event(5, 5, 'h800000, STATUS_ABSORB, CLASS_CHLOROPLAST, 255, 1'b1,
                             32'h0000_0001));

      configure(32'h0000_0000, 32'hFFFF_FFFF, 24'h000000);
      run_random(300);
      configure(32'hFFFF_FFFF, 32'h0000_0000, 24'h800000);
      run_random(300);
      configure(32'h0002_8000, 32'h0002_0000, 24'h040000);
      run_random(300);
      configure(32'h0000_C000, 32'h0000_4000, 24'h000400);
      idling = 1'b0;
      run_random(300);

      drain();
      if (mismatch_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule
